@@ hdl/can_filter_bank_allocator_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the CAN filter bank allocator
// Shared shorthand for concurrent assertions clocked on clk.
// ----------------------------------------------------------------------------
`ifndef CAN_FILTER_BANK_ALLOCATOR_DEFINES_SVH
`define CAN_FILTER_BANK_ALLOCATOR_DEFINES_SVH

// Assertion that is switched off while reset is held.
`define CFBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that is also checked during reset.
`define CFBA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/cfba_pkg.sv @@
// ----------------------------------------------------------------------------
// CAN filter bank allocator package
// Shared constants, codes, types and the filter key function.
// ----------------------------------------------------------------------------
package cfba_pkg;

  // Default number of filter banks.
  localparam int NUM_BANKS_DEF = 14;

  // Field widths.
  localparam int MSG_ID_W   = 29;
  localparam int WORD_W     = 32;
  localparam int BANK_NUM_W = 4;
  localparam int STD_ID_W   = 11;
  localparam int STD_SHIFT  = 21;
  localparam int EXT_SHIFT  = 3;

  // Request codes.
  localparam logic REQ_SUBSCRIBE   = 1'b0;
  localparam logic REQ_UNSUBSCRIBE = 1'b1;

  // Result status codes.
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_NO_BANK = 1'b1;

  // Bank fill codes.
  typedef logic [1:0] fill_t;
  localparam fill_t FILL_EMPTY = 2'd0;
  localparam fill_t FILL_HALF  = 2'd1;
  localparam fill_t FILL_FULL  = 2'd2;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic addr_last;
    logic out_busy;
  } stat_t;

  // Build the list-mode filter word for one identifier.
  function automatic logic [WORD_W-1:0] make_key(input logic [MSG_ID_W-1:0] id,
                                                 input logic ext,
                                                 input logic rtr);
    logic [WORD_W-1:0] k;
    if (ext) begin
      k = {id, EXT_SHIFT'(3'b100)};
    end else begin
      k = {id[STD_ID_W-1:0], STD_SHIFT'(0)};
    end
    k[1] = rtr;
    return k;
  endfunction

endpackage

@@ hdl/cfba_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module cfba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/cfba_ctrl.sv @@
// ----------------------------------------------------------------------------
// CAN filter bank allocator controller
// Sequences load, bank scan, drain and commit of one request item.
// ----------------------------------------------------------------------------
module cfba_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  cfba_pkg::stat_t stat,
  output cfba_pkg::cmd_t  cmd
);
  import cfba_pkg::*;

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.addr_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_nxt = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (!stat.out_busy) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.scan   = 1'b0;
    cmd.commit = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_COMMIT: begin
        cmd.commit = !stat.out_busy;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ hdl/cfba_dp.sv @@
// ----------------------------------------------------------------------------
// CAN filter bank allocator datapath
// Bank tables, key store, scan compare, bank choice and result register.
// ----------------------------------------------------------------------------
module cfba_dp #(
  parameter int NUM_BANKS = cfba_pkg::NUM_BANKS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  cfba_pkg::cmd_t                   cmd,
  output cfba_pkg::stat_t                  stat,
  input  logic                             in_req_type,
  input  logic [cfba_pkg::MSG_ID_W-1:0]    in_msg_id,
  input  logic                             in_extended,
  input  logic                             in_remote,
  input  logic                             in_fifo_sel,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_status,
  output logic                             out_bank_write,
  output logic [cfba_pkg::BANK_NUM_W-1:0]  out_bank_number,
  output logic [cfba_pkg::WORD_W-1:0]      out_first_word,
  output logic [cfba_pkg::WORD_W-1:0]      out_second_word,
  output logic                             out_bank_enable,
  output logic                             out_bank_fifo
);
  import cfba_pkg::*;

  localparam int BW = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;

  // Request registers.
  logic              req_type_r;
  logic              fifo_r;
  logic [WORD_W-1:0] key_r;

  // Scan pipeline.
  logic [BW-1:0] addr_r;
  logic [BW-1:0] cmp_idx_r;
  logic          cmp_vld_r;

  // Bank tables.
  fill_t fill_r  [NUM_BANKS];
  logic  queue_r [NUM_BANKS];

  // Scan results.
  logic              found_r, hit_r;
  logic [BW-1:0]     chosen_r;
  fill_t             ch_fill_r;
  logic [WORD_W-1:0] ch_k0_r, ch_k1_r;

  // Key store read data.
  logic [WORD_W-1:0] rd0, rd1;

  // Compare stage signals.
  fill_t cur_fill;
  logic  cur_queue, cur_holds, cur_sel, cur_dup;

  // Commit signals.
  logic              res_status, res_write, res_enable;
  logic [WORD_W-1:0] res_w1, res_w2, ram0_d, ram1_d, surv;
  fill_t             new_fill;
  logic              ram_we;
  logic [BW+BANK_NUM_W-1:0] bank_ext;

  // Output registers.
  logic                  out_valid_r;
  logic                  out_status_r, out_write_r, out_enable_r, out_fifo_r;
  logic [BANK_NUM_W-1:0] out_bank_r;
  logic [WORD_W-1:0]     out_w1_r, out_w2_r;

  // Capture the request item and form its filter key.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_type_r <= in_req_type;
      fifo_r     <= in_fifo_sel;
      key_r      <= make_key(in_msg_id, in_extended, in_remote);
    end
  end

  // Scan address counter and compare-stage valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r    <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        addr_r <= '0;
      end else if (cmd.scan) begin
        addr_r <= addr_r + BW'(1);
      end
      cmp_vld_r <= cmd.scan;
    end
  end

  // The compare stage sees the bank whose keys were read last cycle.
  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      cmp_idx_r <= addr_r;
    end
  end

  assign stat.addr_last = (addr_r == BW'(NUM_BANKS - 1));
  assign stat.out_busy  = out_valid_r & ~out_ready;

  // Key store: first and second list entry of every bank.
  assign ram_we = cmd.commit & res_write;

  cfba_ram #(.WIDTH(WORD_W), .DEPTH(NUM_BANKS)) u_slot0 (
    .clk  (clk),
    .we   (ram_we),
    .waddr(chosen_r),
    .wdata(ram0_d),
    .raddr(addr_r),
    .rdata(rd0)
  );

  cfba_ram #(.WIDTH(WORD_W), .DEPTH(NUM_BANKS)) u_slot1 (
    .clk  (clk),
    .we   (ram_we),
    .waddr(chosen_r),
    .wdata(ram1_d),
    .raddr(addr_r),
    .rdata(rd1)
  );

  // Compare one bank against the request.
  always_comb begin
    cur_fill  = fill_r[cmp_idx_r];
    cur_queue = queue_r[cmp_idx_r];
    cur_holds = (cur_fill != FILL_EMPTY) &&
                ((rd0 == key_r) || ((cur_fill != FILL_HALF) && (rd1 == key_r)));
    cur_sel   = 1'b0;
    cur_dup   = 1'b0;
    if (req_type_r == REQ_SUBSCRIBE) begin
      if (cur_fill == FILL_EMPTY) begin
        cur_sel = 1'b1;
      end else if (cur_queue == fifo_r) begin
        cur_dup = cur_holds;
        cur_sel = (cur_fill == FILL_HALF);
      end
    end else begin
      cur_sel = (cur_queue == fifo_r) && cur_holds;
    end
  end

  // Scan flags; the highest matching bank wins.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      hit_r   <= 1'b0;
    end else if (cmd.load) begin
      found_r <= 1'b0;
      hit_r   <= 1'b0;
    end else if (cmp_vld_r) begin
      if (cur_sel) found_r <= 1'b1;
      if (cur_dup) hit_r <= 1'b1;
    end
  end

  // Keep the chosen bank's contents.
  always_ff @(posedge clk) begin
    if (cmp_vld_r && cur_sel) begin
      chosen_r  <= cmp_idx_r;
      ch_fill_r <= cur_fill;
      ch_k0_r   <= rd0;
      ch_k1_r   <= rd1;
    end
  end

  // Work out the bank update and the result item.
  assign surv = (ch_k0_r == key_r) ? ch_k1_r : ch_k0_r;

  always_comb begin
    res_status = STATUS_OK;
    res_write  = 1'b0;
    res_enable = 1'b0;
    res_w1     = '0;
    res_w2     = '0;
    ram0_d     = '0;
    ram1_d     = '0;
    new_fill   = FILL_EMPTY;
    if (req_type_r == REQ_SUBSCRIBE) begin
      if (!hit_r) begin
        if (!found_r) begin
          res_status = STATUS_NO_BANK;
        end else begin
          res_write  = 1'b1;
          res_enable = 1'b1;
          res_w2     = key_r;
          if (ch_fill_r == FILL_EMPTY) begin
            res_w1   = key_r;
            ram0_d   = key_r;
            new_fill = FILL_HALF;
          end else begin
            res_w1   = ch_k0_r;
            ram0_d   = ch_k0_r;
            ram1_d   = key_r;
            new_fill = FILL_FULL;
          end
        end
      end
    end else if (found_r) begin
      res_write = 1'b1;
      if (ch_fill_r != FILL_HALF) begin
        // A full bank keeps the survivor in its first entry.
        res_enable = 1'b1;
        res_w1     = surv;
        res_w2     = surv;
        ram0_d     = surv;
        new_fill   = FILL_HALF;
      end
    end
  end

  // Bank fill and FIFO tables.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BANKS; i++) begin
        fill_r[i]  <= FILL_EMPTY;
        queue_r[i] <= 1'b0;
      end
    end else if (ram_we) begin
      fill_r[chosen_r]  <= new_fill;
      queue_r[chosen_r] <= fifo_r;
    end
  end

  // Result register.
  assign bank_ext = (BW + BANK_NUM_W)'(chosen_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r <= res_status;
      out_write_r  <= res_write;
      out_bank_r   <= res_write ? bank_ext[BANK_NUM_W-1:0] : '0;
      out_w1_r     <= res_w1;
      out_w2_r     <= res_w2;
      out_enable_r <= res_enable;
      out_fifo_r   <= res_write ? fifo_r : 1'b0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_bank_write  = out_write_r;
  assign out_bank_number = out_bank_r;
  assign out_first_word  = out_w1_r;
  assign out_second_word = out_w2_r;
  assign out_bank_enable = out_enable_r;
  assign out_bank_fifo   = out_fifo_r;

endmodule

@@ hdl/can_filter_bank_allocator.sv @@
// ----------------------------------------------------------------------------
// CAN filter bank allocator
// Subscribes and unsubscribes CAN identifiers in a table of list-mode banks.
// ----------------------------------------------------------------------------
// Usage: a request item (subscribe or unsubscribe, identifier, frame kind and
// receive FIFO) is taken on the in_ channel when in_valid and in_ready are
// both high. Each request gives exactly one result item on the out_ channel:
// a status, and when a bank changes, its number, both filter words, enable
// and FIFO.
// Sequence: after the accept the block scans the banks, drains the compare
// stage and commits the result. The bank keys are read from the key store
// one bank per cycle, so a request occupies the block for the whole scan,
// and in_ready stays low from the accept until the block is back in idle.
// A result waits in an output register; the next request is taken while it
// waits. If the receiver still stalls when the following result is ready,
// the block holds that result back and takes no new item until the
// register frees.
// Reset: all banks read as empty and on FIFO 0; no result is pending.
// ----------------------------------------------------------------------------
module can_filter_bank_allocator #(
  parameter int NUM_BANKS = cfba_pkg::NUM_BANKS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_req_type,
  input  logic [cfba_pkg::MSG_ID_W-1:0]   in_msg_id,
  input  logic                            in_extended,
  input  logic                            in_remote,
  input  logic                            in_fifo_sel,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_status,
  output logic                            out_bank_write,
  output logic [cfba_pkg::BANK_NUM_W-1:0] out_bank_number,
  output logic [cfba_pkg::WORD_W-1:0]     out_first_word,
  output logic [cfba_pkg::WORD_W-1:0]     out_second_word,
  output logic                            out_bank_enable,
  output logic                            out_bank_fifo
);
  import cfba_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Request sequencer.
  cfba_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  // Bank tables and result path.
  cfba_dp #(.NUM_BANKS(NUM_BANKS)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_req_type    (in_req_type),
    .in_msg_id      (in_msg_id),
    .in_extended    (in_extended),
    .in_remote      (in_remote),
    .in_fifo_sel    (in_fifo_sel),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_bank_write (out_bank_write),
    .out_bank_number(out_bank_number),
    .out_first_word (out_first_word),
    .out_second_word(out_second_word),
    .out_bank_enable(out_bank_enable),
    .out_bank_fifo  (out_bank_fifo)
  );

endmodule

@@ hdl/cfba_checker.sv @@
// ----------------------------------------------------------------------------
// CAN filter bank allocator port checker
// Concurrent assertions on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "can_filter_bank_allocator_defines.svh"

module cfba_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            out_status,
  input logic                            out_bank_write,
  input logic [cfba_pkg::BANK_NUM_W-1:0] out_bank_number,
  input logic [cfba_pkg::WORD_W-1:0]     out_first_word,
  input logic [cfba_pkg::WORD_W-1:0]     out_second_word,
  input logic                            out_bank_enable,
  input logic                            out_bank_fifo
);

  // A stalled result item stays put.
  `CFBA_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_first_word) && $stable(out_second_word) && $stable(out_bank_number), "stalled result item changed")

  // Reset leaves no result pending.
  `CFBA_ASSERT_RST(a_rst_idle, !rst_n |=> !out_valid, "result pending after reset")

  // The block is busy for the cycle after it takes an item.
  `CFBA_ASSERT(a_busy, in_valid && in_ready |=> !in_ready, "item taken while busy")

  // A result without a bank write carries all-zero bank fields.
  `CFBA_ASSERT(a_nowrite_zero, out_valid && !out_bank_write |-> out_bank_number == 0 && out_first_word == 0 && out_second_word == 0 && !out_bank_enable && !out_bank_fifo, "bank fields set without a write")

  // A deactivated bank is written with zero words and never with an error.
  `CFBA_ASSERT(a_disable_zero, out_valid && out_bank_write && !out_bank_enable |-> out_first_word == 0 && out_second_word == 0 && !out_status, "deactivated bank carries words")

endmodule

bind can_filter_bank_allocator cfba_checker u_cfba_checker (.*);

@@ tb/sv/can_filter_bank_allocator_test.sv @@
// ----------------------------------------------------------------------------
// CAN filter bank allocator testbench
// Drives subscribe and unsubscribe requests through the valid/ready input,
// keeps its own copy of the filter bank table to work out the bank update
// each request should cause, and checks every result item field by field.
// Both sides idle at random. The receiver also holds off once for a long
// stretch, and the sender pauses twice until the table has settled.
// ----------------------------------------------------------------------------
module can_filter_bank_allocator_test;
  import cfba_pkg::*;

  localparam int HALF_PERIOD    = 5;
  localparam int RESET_CYCLES   = 5;
  localparam int BANKS          = NUM_BANKS_DEF;
  localparam int POOL_SIZE      = 48;
  localparam int RANDOM_ITEMS   = 830;
  localparam int HOLDOFF_AT     = 250;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int SETTLE_CYCLES  = 40;
  localparam int CYCLE_LIMIT    = 300000;

  // Identifier-extension and remote-request bits of a list-mode filter word.
  localparam logic [WORD_W-1:0] KEY_IDE = 32'h4;
  localparam logic [WORD_W-1:0] KEY_RTR = 32'h2;

  typedef struct packed {
    logic                req_type;
    logic [MSG_ID_W-1:0] msg_id;
    logic                extended;
    logic                remote;
    logic                fifo_sel;
    logic                wait_for_idle;
  } request_t;

  typedef struct packed {
    logic                  status;
    logic                  bank_write;
    logic [BANK_NUM_W-1:0] bank_number;
    logic [WORD_W-1:0]     first_word;
    logic [WORD_W-1:0]     second_word;
    logic                  bank_enable;
    logic                  bank_fifo;
  } bank_update_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_req_type = REQ_SUBSCRIBE;
  logic [MSG_ID_W-1:0]   in_msg_id = '0;
  logic                  in_extended = 1'b0;
  logic                  in_remote = 1'b0;
  logic                  in_fifo_sel = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_status;
  logic                  out_bank_write;
  logic [BANK_NUM_W-1:0] out_bank_number;
  logic [WORD_W-1:0]     out_first_word;
  logic [WORD_W-1:0]     out_second_word;
  logic                  out_bank_enable;
  logic                  out_bank_fifo;

  // Shadow copy of the filter bank table.
  fill_t             bank_fill [BANKS];
  logic              bank_queue [BANKS];
  logic [WORD_W-1:0] slot_key [2*BANKS];

  request_t     request_q[$];
  bank_update_t bank_update_q[$];

  int send_gap = 0;
  int send_calm = 0;
  int recv_wait = 0;
  int recv_calm = 0;
  int results_seen = 0;
  int mismatches = 0;
  int cycle_count = 0;

  can_filter_bank_allocator u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_msg_id       (in_msg_id),
    .in_extended     (in_extended),
    .in_remote       (in_remote),
    .in_fifo_sel     (in_fifo_sel),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_bank_write  (out_bank_write),
    .out_bank_number (out_bank_number),
    .out_first_word  (out_first_word),
    .out_second_word (out_second_word),
    .out_bank_enable (out_bank_enable),
    .out_bank_fifo   (out_bank_fifo)
  );

  // Free-running clock.
  always #HALF_PERIOD clk = ~clk;

  // Run guard: a stuck handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("can_filter_bank_allocator_test failed");
      $finish;
    end
  end

  // Wait before the next item: mostly random, with occasional runs of no idling.
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  function automatic bit bank_has_key(input int b, input logic [WORD_W-1:0] key);
    if (bank_fill[b] == FILL_EMPTY) return 1'b0;
    return slot_key[2*b] == key || (bank_fill[b] != FILL_HALF && slot_key[2*b+1] == key);
  endfunction

  // Apply one request to the shadow table and return the bank update it causes.
  function automatic bank_update_t apply_request(input request_t rq);
    bank_update_t      upd;
    logic [WORD_W-1:0] key;
    logic [WORD_W-1:0] word;
    int                pick;
    bit                already_held;
    upd = '0;
    pick = -1;
    already_held = 1'b0;
    if (rq.extended) begin
      key = (WORD_W'(rq.msg_id) << EXT_SHIFT) | KEY_IDE;
    end else begin
      key = WORD_W'(rq.msg_id[STD_ID_W-1:0]) << STD_SHIFT;
    end
    if (rq.remote) key = key | KEY_RTR;

    if (rq.req_type == REQ_SUBSCRIBE) begin
      // Highest bank that is empty, or half-full on the same FIFO.
      for (int i = 0; i < BANKS; i++) begin
        if (bank_fill[i] == FILL_EMPTY) begin
          pick = i;
        end else if (bank_queue[i] == rq.fifo_sel) begin
          if (bank_has_key(i, key)) already_held = 1'b1;
          else if (bank_fill[i] == FILL_HALF) pick = i;
        end
      end
      if (already_held) return upd;
      if (pick < 0) begin
        upd.status = STATUS_NO_BANK;
        return upd;
      end
      if (bank_fill[pick] == FILL_EMPTY) begin
        word = key;
        slot_key[2*pick] = key;
        slot_key[2*pick+1] = '0;
        bank_fill[pick] = FILL_HALF;
      end else begin
        word = slot_key[2*pick];
        slot_key[2*pick+1] = key;
        bank_fill[pick] = FILL_FULL;
      end
      upd.first_word = word;
      upd.second_word = key;
      upd.bank_enable = 1'b1;
    end else begin
      for (int i = 0; i < BANKS; i++) begin
        if (bank_queue[i] == rq.fifo_sel && bank_has_key(i, key)) pick = i;
      end
      if (pick < 0) return upd;
      if (bank_fill[pick] == FILL_HALF) begin
        // Last key leaves: the bank is cleared and switched off.
        slot_key[2*pick] = '0;
        slot_key[2*pick+1] = '0;
        bank_fill[pick] = FILL_EMPTY;
        word = '0;
        upd.bank_enable = 1'b0;
      end else begin
        // The surviving key moves to the first slot.
        word = (slot_key[2*pick] == key) ? slot_key[2*pick+1] : slot_key[2*pick];
        slot_key[2*pick] = word;
        slot_key[2*pick+1] = '0;
        bank_fill[pick] = FILL_HALF;
        upd.bank_enable = 1'b1;
      end
      upd.first_word = word;
      upd.second_word = word;
    end
    bank_queue[pick] = rq.fifo_sel;
    upd.status = STATUS_OK;
    upd.bank_write = 1'b1;
    upd.bank_number = BANK_NUM_W'(pick);
    upd.bank_fifo = rq.fifo_sel;
    return upd;
  endfunction

  task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                 input logic [WORD_W-1:0] want);
    mismatches++;
    $display("mismatch on result %0d: %s got %h expected %h", results_seen, what, got, want);
  endtask

  task automatic queue_request(input logic rt, input logic [MSG_ID_W-1:0] id,
                               input logic ext, input logic rtr, input logic fifo,
                               input logic hold);
    request_t rq;
    rq.req_type = rt;
    rq.msg_id = id;
    rq.extended = ext;
    rq.remote = rtr;
    rq.fifo_sel = fifo;
    rq.wait_for_idle = hold;
    request_q.push_back(rq);
  endtask

  // Sender: offers queued items, predicting each one as it is accepted.
  always @(posedge clk) begin : drive_requests
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = draw_wait(send_calm);
    end else begin
      if (in_valid && in_ready) begin
        bank_update_q.push_back(apply_request(request_q.pop_front()));
        send_gap = draw_wait(send_calm);
      end
      if (in_valid && !in_ready) begin
        // Item still on offer: hold it unchanged.
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (request_q.size() != 0 &&
                   !(request_q[0].wait_for_idle && bank_update_q.size() != 0)) begin
        in_valid <= 1'b1;
        in_req_type <= request_q[0].req_type;
        in_msg_id <= request_q[0].msg_id;
        in_extended <= request_q[0].extended;
        in_remote <= request_q[0].remote;
        in_fifo_sel <= request_q[0].fifo_sel;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: takes result items with random stalls and checks each one.
  always @(posedge clk) begin : check_updates
    bank_update_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_wait = draw_wait(recv_calm);
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (bank_update_q.size() == 0) begin
          report_mismatch("result with nothing expected", '0, '0);
        end else begin
          want = bank_update_q.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", WORD_W'(out_status), WORD_W'(want.status));
          if (out_bank_write !== want.bank_write)
            report_mismatch("bank_write", WORD_W'(out_bank_write),
                            WORD_W'(want.bank_write));
          if (out_bank_number !== want.bank_number)
            report_mismatch("bank_number", WORD_W'(out_bank_number),
                            WORD_W'(want.bank_number));
          if (out_first_word !== want.first_word)
            report_mismatch("first_word", out_first_word, want.first_word);
          if (out_second_word !== want.second_word)
            report_mismatch("second_word", out_second_word, want.second_word);
          if (out_bank_enable !== want.bank_enable)
            report_mismatch("bank_enable", WORD_W'(out_bank_enable),
                            WORD_W'(want.bank_enable));
          if (out_bank_fifo !== want.bank_fifo)
            report_mismatch("bank_fifo", WORD_W'(out_bank_fifo), WORD_W'(want.bank_fifo));
        end
        recv_wait = draw_wait(recv_calm);
        // One long stall so that the block backs up and stops taking items.
        if (results_seen == HOLDOFF_AT) recv_wait = HOLDOFF_CYCLES;
      end
      if (recv_wait > 0) begin
        recv_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin : stimulus
    logic [MSG_ID_W-1:0] pool_id [POOL_SIZE];
    logic                pool_ext [POOL_SIZE];
    logic                pool_rtr [POOL_SIZE];
    logic [MSG_ID_W-1:0] id;
    logic                ext;
    logic                rtr;
    logic                rt;
    int                  sub_pct;
    int                  p;

    for (int b = 0; b < BANKS; b++) begin
      bank_fill[b] = FILL_EMPTY;
      bank_queue[b] = 1'b0;
      slot_key[2*b] = '0;
      slot_key[2*b+1] = '0;
    end

    // Directed part: fill and empty banks on both FIFOs, duplicates, absent keys.
    queue_request(REQ_SUBSCRIBE, 29'h0, 1'b0, 1'b0, 1'b0, 1'b0);
    // Bits above the standard identifier must not matter.
    queue_request(REQ_SUBSCRIBE, 29'h1FFFF800, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_request(REQ_SUBSCRIBE, 29'h0, 1'b0, 1'b0, 1'b1, 1'b0);
    queue_request(REQ_SUBSCRIBE, 29'h1FFFFFFF, 1'b1, 1'b1, 1'b0, 1'b0);
    queue_request(REQ_SUBSCRIBE, 29'h1FFFFFFF, 1'b0, 1'b1, 1'b1, 1'b0);
    queue_request(REQ_SUBSCRIBE, 29'h0, 1'b1, 1'b0, 1'b0, 1'b0);
    queue_request(REQ_UNSUBSCRIBE, 29'h123, 1'b1, 1'b0, 1'b0, 1'b0);
    // Held key, but on the other FIFO.
    queue_request(REQ_UNSUBSCRIBE, 29'h1FFFFFFF, 1'b1, 1'b1, 1'b1, 1'b0);
    // First slot of a full bank removed, then the last key of that bank.
    queue_request(REQ_UNSUBSCRIBE, 29'h0, 1'b0, 1'b0, 1'b0, 1'b0);
    queue_request(REQ_UNSUBSCRIBE, 29'h1FFFFFFF, 1'b1, 1'b1, 1'b0, 1'b0);
    // Second slot of a full bank removed.
    queue_request(REQ_UNSUBSCRIBE, 29'h7FF, 1'b0, 1'b1, 1'b1, 1'b0);
    queue_request(REQ_UNSUBSCRIBE, 29'h0, 1'b0, 1'b0, 1'b1, 1'b0);
    queue_request(REQ_UNSUBSCRIBE, 29'h0, 1'b1, 1'b0, 1'b0, 1'b0);
    queue_request(REQ_SUBSCRIBE, 29'h15555555, 1'b1, 1'b0, 1'b1, 1'b0);
    queue_request(REQ_SUBSCRIBE, 29'h2AA, 1'b0, 1'b1, 1'b0, 1'b0);
    queue_request(REQ_SUBSCRIBE, 29'h0AAAAAAA, 1'b1, 1'b1, 1'b1, 1'b0);
    // Same identifier as a held key, but a data frame instead of a remote one.
    queue_request(REQ_UNSUBSCRIBE, 29'h2AA, 1'b0, 1'b0, 1'b0, 1'b0);

    // A pool of identifiers keeps keys recurring, so duplicates, removals
    // and a full table all come up.
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_id[i] = MSG_ID_W'($urandom);
      pool_ext[i] = 1'($urandom_range(0, 1));
      pool_rtr[i] = 1'($urandom_range(0, 1));
    end

    // Random part in phases that lean towards filling or towards emptying.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case ((n / 100) % 4)
        0:       sub_pct = 90;
        1:       sub_pct = 50;
        2:       sub_pct = 25;
        default: sub_pct = 70;
      endcase
      rt = ($urandom_range(0, 99) < sub_pct) ? REQ_SUBSCRIBE : REQ_UNSUBSCRIBE;
      if ($urandom_range(0, 99) < 85) begin
        p = $urandom_range(0, POOL_SIZE - 1);
        id = pool_id[p];
        ext = pool_ext[p];
        rtr = pool_rtr[p];
        if (!ext) id[MSG_ID_W-1:STD_ID_W] = (MSG_ID_W-STD_ID_W)'($urandom);
      end else begin
        id = MSG_ID_W'($urandom);
        ext = 1'($urandom_range(0, 1));
        rtr = 1'($urandom_range(0, 1));
      end
      queue_request(rt, id, ext, rtr, 1'($urandom_range(0, 1)),
                    (n == 0 || n == RANDOM_ITEMS / 2) ? 1'b1 : 1'b0);
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    while (request_q.size() != 0 || in_valid || bank_update_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("can_filter_bank_allocator_test passed");
    end else begin
      $display("can_filter_bank_allocator_test failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/cfba_pkg.sv
hdl/cfba_ram.sv
hdl/cfba_ctrl.sv
hdl/cfba_dp.sv
hdl/can_filter_bank_allocator.sv
hdl/cfba_checker.sv
tb/sv/can_filter_bank_allocator_test.sv
